// File: src/sact_pkg.sv
// Shared geometry constants and types of the cache tag controller.
package sact_pkg;

    // Cache geometry.
    localparam int CACHE_BYTES = 32768;
    localparam int ADDR_BITS   = 32;

    // One row holds both ways of a two-way set, or two consecutive direct-mapped lines.
    localparam int ROWS      = CACHE_BYTES / 64;
    localparam int ROW_BITS  = $clog2(ROWS);
    localparam int DM_SPLIT  = $clog2(CACHE_BYTES);
    localparam int TW_SPLIT  = DM_SPLIT - 1;
    localparam int TAG_BITS  = ADDR_BITS - TW_SPLIT;
    localparam int DM_TAG_BITS = ADDR_BITS - DM_SPLIT;

    // Request queue between front and back.
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_BITS   = $clog2(QUEUE_DEPTH);

    // Configuration register indexes.
    localparam int CFG_IDX_BITS = 2;
    localparam logic [CFG_IDX_BITS-1:0] CFG_LINE_64 = 2'd0;
    localparam logic [CFG_IDX_BITS-1:0] CFG_TWO_WAY = 2'd1;
    localparam logic [CFG_IDX_BITS-1:0] CFG_USE_LRU = 2'd2;

    // Access commands.
    localparam logic CMD_LOAD  = 1'b0;
    localparam logic CMD_STORE = 1'b1;

    // A classified request as it waits in the queue.
    typedef struct packed {
        logic                is_store;
        logic                two_way;
        logic                use_lru;
        logic                dm_way;
        logic [ROW_BITS-1:0] row;
        logic [TAG_BITS-1:0] tag;
    } q_entry_t;

    // One tag memory row.
    typedef struct packed {
        logic                victim;
        logic                valid1;
        logic [TAG_BITS-1:0] tag1;
        logic                valid0;
        logic [TAG_BITS-1:0] tag0;
    } tag_row_t;

endpackage

// File: src/set_assoc_cache_tag_controller_unit.sv
// Top level of the set-associative cache tag and replacement controller.
//
//   channel  direction  handshake          payload
//   s_       in         s_valid/s_ready    s_command, s_address
//   m_       out        m_valid/m_ready    m_hit, m_filled, m_hit_total, m_miss_total
//   cfg_     in         cfg_we             cfg_index, cfg_data
//
// In the back end ST_IDLE reads each request's tag row and ST_LOOK then resolves it and
// writes the row back; no new request is taken until that is done, since the single tag
// memory port pair and this read-then-write per row allow no overlap.
// After reset a clearing pass runs over all 512 tag rows with s_ready low.
// While the back end waits on a full result register, the queue fills until full.
module set_assoc_cache_tag_controller_unit (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              s_valid,
    output logic                              s_ready,
    input  logic                              s_command,
    input  logic [sact_pkg::ADDR_BITS-1:0]    s_address,
    output logic                              m_valid,
    input  logic                              m_ready,
    output logic                              m_hit,
    output logic                              m_filled,
    output logic [31:0]                       m_hit_total,
    output logic [31:0]                       m_miss_total,
    input  logic                              cfg_we,
    input  logic [sact_pkg::CFG_IDX_BITS-1:0] cfg_index,
    input  logic                              cfg_data
);
    import sact_pkg::*;

    logic     line_64_reg, two_way_reg, use_lru_reg;
    logic     push, pop, q_not_empty, q_full, back_clearing;
    q_entry_t push_entry, q_head;

    // Configuration registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            line_64_reg <= 1'b0;
            two_way_reg <= 1'b0;
            use_lru_reg <= 1'b0;
        end else if (cfg_we) begin
            unique case (cfg_index)
                CFG_LINE_64: line_64_reg <= cfg_data;
                CFG_TWO_WAY: two_way_reg <= cfg_data;
                CFG_USE_LRU: use_lru_reg <= cfg_data;
                default: begin
                end
            endcase
        end
    end

    sact_front u_front (
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_command     (s_command),
        .s_address     (s_address),
        .line_64       (line_64_reg),
        .two_way       (two_way_reg),
        .use_lru       (use_lru_reg),
        .queue_full    (q_full),
        .back_clearing (back_clearing),
        .push          (push),
        .entry         (push_entry)
    );

    sact_queue u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push       (push),
        .push_entry (push_entry),
        .pop        (pop),
        .not_empty  (q_not_empty),
        .full       (q_full),
        .head       (q_head)
    );

    sact_back u_back (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .q_valid      (q_not_empty),
        .q_head       (q_head),
        .q_pop        (pop),
        .clearing     (back_clearing),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_hit        (m_hit),
        .m_filled     (m_filled),
        .m_hit_total  (m_hit_total),
        .m_miss_total (m_miss_total)
    );

endmodule

// File: src/sact_front.sv
// Front end: accepts access requests and splits the address into row, way and tag.
module sact_front (
    input  logic                          s_valid,
    output logic                          s_ready,
    input  logic                          s_command,
    input  logic [sact_pkg::ADDR_BITS-1:0] s_address,
    input  logic                          line_64,
    input  logic                          two_way,
    input  logic                          use_lru,
    input  logic                          queue_full,
    input  logic                          back_clearing,
    output logic                          push,
    output sact_pkg::q_entry_t             entry
);
    import sact_pkg::*;

    logic [ROW_BITS:0]   dm_line;
    logic [ROW_BITS-1:0] tw_set;

    // Requests wait while the tag memory is cleared or the queue is full.
    assign s_ready = !queue_full && !back_clearing;
    assign push    = s_valid && s_ready;

    // Set index: the offset is five or six bits, the rest up to the tag boundary.
    always_comb begin
        if (line_64) begin
            dm_line = {1'b0, s_address[DM_SPLIT-1:6]};
            tw_set  = {1'b0, s_address[TW_SPLIT-1:6]};
        end else begin
            dm_line = s_address[DM_SPLIT-1:5];
            tw_set  = s_address[TW_SPLIT-1:5];
        end
    end

    // Build the queue entry for the selected organization.
    always_comb begin
        entry.is_store = (s_command == CMD_STORE);
        entry.two_way  = two_way;
        entry.use_lru  = use_lru;
        if (two_way) begin
            entry.dm_way = 1'b0;
            entry.row    = tw_set;
            entry.tag    = s_address[ADDR_BITS-1:TW_SPLIT];
        end else begin
            entry.dm_way = dm_line[0];
            entry.row    = dm_line[ROW_BITS:1];
            entry.tag    = {{(TAG_BITS-DM_TAG_BITS){1'b0}}, s_address[ADDR_BITS-1:DM_SPLIT]};
        end
    end

endmodule

// File: src/sact_queue.sv
// Short request queue between the front end and the back end.
module sact_queue (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               push,
    input  sact_pkg::q_entry_t push_entry,
    input  logic               pop,
    output logic               not_empty,
    output logic               full,
    output sact_pkg::q_entry_t head
);
    import sact_pkg::*;

    q_entry_t             slots_reg [QUEUE_DEPTH];
    logic [QPTR_BITS-1:0] wr_ptr_reg, wr_ptr_next;
    logic [QPTR_BITS-1:0] rd_ptr_reg, rd_ptr_next;
    logic [QPTR_BITS:0]   count_reg, count_next;

    assign not_empty = (count_reg != '0);
    assign full      = (count_reg == (QPTR_BITS+1)'(QUEUE_DEPTH));
    assign head      = slots_reg[rd_ptr_reg];

    // Pointer and fill count updates.
    always_comb begin
        wr_ptr_next = push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = pop  ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg;
        if (push && !pop) begin
            count_next = count_reg + 1'b1;
        end else if (pop && !push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Entry storage.
    always_ff @(posedge aclk) begin
        if (push) begin
            slots_reg[wr_ptr_reg] <= push_entry;
        end
    end

endmodule

// File: src/sact_back.sv
// Back end: tag memory, hit check, fill and replacement, counters and result register.
module sact_back (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          q_valid,
    input  sact_pkg::q_entry_t             q_head,
    output logic                          q_pop,
    output logic                          clearing,
    output logic                          m_valid,
    input  logic                          m_ready,
    output logic                          m_hit,
    output logic                          m_filled,
    output logic [31:0]                   m_hit_total,
    output logic [31:0]                   m_miss_total
);
    import sact_pkg::*;

    typedef enum logic [1:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_LOOK
    } state_t;

    state_t              state_reg, state_next;
    logic [ROW_BITS-1:0] clr_idx_reg, clr_idx_next;
    q_entry_t            entry_reg, entry_next;
    logic [31:0]         hit_cnt_reg, hit_cnt_next;
    logic [31:0]         miss_cnt_reg, miss_cnt_next;
    logic                m_valid_reg, m_valid_next;
    logic                m_hit_reg, m_hit_next;
    logic                m_filled_reg, m_filled_next;

    tag_row_t            mem [ROWS];
    tag_row_t            rd_row_reg;
    tag_row_t            new_row;
    tag_row_t            wr_row;
    logic [ROW_BITS-1:0] wr_addr;
    logic                wr_en;

    logic h0, h1, hit, do_fill, fill_way;

    assign clearing     = (state_reg == ST_CLEAR);
    assign q_pop        = (state_reg == ST_IDLE) && q_valid && (!m_valid_reg || m_ready);
    assign m_valid      = m_valid_reg;
    assign m_hit        = m_hit_reg;
    assign m_filled     = m_filled_reg;
    assign m_hit_total  = hit_cnt_reg;
    assign m_miss_total = miss_cnt_reg;

    // Hit check, way choice and the updated row.
    always_comb begin
        h0 = rd_row_reg.valid0 && (rd_row_reg.tag0 == entry_reg.tag);
        h1 = rd_row_reg.valid1 && (rd_row_reg.tag1 == entry_reg.tag);
        new_row = rd_row_reg;
        if (entry_reg.two_way) begin
            hit = h0 || h1;
            if (!rd_row_reg.valid0) begin
                fill_way = 1'b0;
            end else if (!rd_row_reg.valid1) begin
                fill_way = 1'b1;
            end else begin
                fill_way = rd_row_reg.victim;
            end
            if (hit && entry_reg.use_lru) begin
                new_row.victim = h0;
            end else if (!hit && entry_reg.is_store) begin
                new_row.victim = !fill_way;
            end
        end else begin
            hit      = entry_reg.dm_way ? h1 : h0;
            fill_way = entry_reg.dm_way;
        end
        do_fill = !hit && entry_reg.is_store;
        if (do_fill) begin
            if (fill_way) begin
                new_row.valid1 = 1'b1;
                new_row.tag1   = entry_reg.tag;
            end else begin
                new_row.valid0 = 1'b1;
                new_row.tag0   = entry_reg.tag;
            end
        end
    end

    // Memory write port: the clearing pass, or the write-back of a looked-up row.
    always_comb begin
        wr_en   = (state_reg == ST_CLEAR) || (state_reg == ST_LOOK);
        wr_addr = (state_reg == ST_CLEAR) ? clr_idx_reg : entry_reg.row;
        wr_row  = (state_reg == ST_CLEAR) ? tag_row_t'('0) : new_row;
    end

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_row;
        end
        if (q_pop) begin
            rd_row_reg <= mem[q_head.row];
        end
    end

    // Sequencer next state, counters and result register.
    always_comb begin
        state_next    = state_reg;
        clr_idx_next  = clr_idx_reg;
        entry_next    = entry_reg;
        hit_cnt_next  = hit_cnt_reg;
        miss_cnt_next = miss_cnt_reg;
        m_valid_next  = m_valid_reg && !m_ready;
        m_hit_next    = m_hit_reg;
        m_filled_next = m_filled_reg;
        unique case (state_reg)
            ST_CLEAR: begin
                clr_idx_next = clr_idx_reg + 1'b1;
                if (clr_idx_reg == ROW_BITS'(ROWS - 1)) begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (q_pop) begin
                    entry_next = q_head;
                    state_next = ST_LOOK;
                end
            end
            ST_LOOK: begin
                if (hit) begin
                    if (hit_cnt_reg != '1) begin
                        hit_cnt_next = hit_cnt_reg + 1'b1;
                    end
                end else if (miss_cnt_reg != '1) begin
                    miss_cnt_next = miss_cnt_reg + 1'b1;
                end
                m_valid_next  = 1'b1;
                m_hit_next    = hit;
                m_filled_next = do_fill;
                state_next    = ST_IDLE;
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_CLEAR;
            clr_idx_reg  <= '0;
            hit_cnt_reg  <= '0;
            miss_cnt_reg <= '0;
            m_valid_reg  <= 1'b0;
        end else begin
            state_reg    <= state_next;
            clr_idx_reg  <= clr_idx_next;
            hit_cnt_reg  <= hit_cnt_next;
            miss_cnt_reg <= miss_cnt_next;
            m_valid_reg  <= m_valid_next;
        end
        entry_reg    <= entry_next;
        m_hit_reg    <= m_hit_next;
        m_filled_reg <= m_filled_next;
    end

endmodule
